@@ src/dual_wheel_pid_speed_controller_top_assert.svh @@
// assertion macros for the dual wheel pid speed controller
// used by dual_wheel_pid_speed_controller_top; expects clk and rst_n in scope
`ifndef DUAL_WHEEL_PID_SPEED_CONTROLLER_TOP_ASSERT_SVH
`define DUAL_WHEEL_PID_SPEED_CONTROLLER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define DWPID_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DWPID_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DWPID_ASSERT_NOW(name, ante, cons, msg)
`define DWPID_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

@@ src/dwpid_pkg.sv @@
// shared types and constants for the dual wheel pid speed controller
// no dependencies; imported by dwpid_lane and the top level
`default_nettype none

package dwpid_pkg;

  // fixed-point setup
  localparam int INTEGRAL_LIMIT     = 200;
  localparam int GAIN_FRACTION_BITS = 12;

  // field widths
  localparam int GAIN_W  = 16;
  localparam int BASE_W  = 10;
  localparam int DRIVE_W = 11;
  localparam int SPEED_W = 16;
  localparam int LINE_W  = 8;
  localparam int TGT_W   = 12;  // base +- line error
  localparam int ERR_W   = 18;  // target - measured
  localparam int INT_W   = 9;   // clamped integral
  localparam int SUM_W   = 19;  // integral sum and error difference
  localparam int PP_W    = GAIN_W + 1 + ERR_W;
  localparam int PI_W    = GAIN_W + 1 + INT_W;
  localparam int PD_W    = GAIN_W + 1 + SUM_W;
  localparam int ACC_W   = PD_W + 1;
  localparam int SH_W    = ACC_W - GAIN_FRACTION_BITS;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_BASE_SPEED = 3'd3,
    REG_DRIVE_MAX  = 3'd4,
    REG_DRIVE_MIN  = 3'd5
  } cfg_reg_t;

  // stage load strobes handed to each wheel lane
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } lane_ctrl_t;

endpackage

`default_nettype wire

@@ src/dwpid_lane.sv @@
// one wheel's pid lane: error/integral stage, product stage, sum/shift/clamp stage
// depends on dwpid_pkg
`default_nettype none

module dwpid_lane (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire dwpid_pkg::lane_ctrl_t                    ctrl,
  input  wire logic signed [dwpid_pkg::TGT_W-1:0]       target,
  input  wire logic signed [dwpid_pkg::SPEED_W-1:0]     measured,
  input  wire logic        [dwpid_pkg::GAIN_W-1:0]      gain_prop,
  input  wire logic        [dwpid_pkg::GAIN_W-1:0]      gain_integ,
  input  wire logic        [dwpid_pkg::GAIN_W-1:0]      gain_deriv,
  input  wire logic signed [dwpid_pkg::DRIVE_W-1:0]     drive_max,
  input  wire logic signed [dwpid_pkg::DRIVE_W-1:0]     drive_min,
  output logic signed      [dwpid_pkg::DRIVE_W-1:0]     drive
);
  import dwpid_pkg::*;

  localparam logic signed [SUM_W-1:0] ILIM_HI = SUM_W'(INTEGRAL_LIMIT);
  localparam logic signed [SUM_W-1:0] ILIM_LO = -SUM_W'(INTEGRAL_LIMIT);

  // wheel state
  logic signed [ERR_W-1:0] last_err_r;
  logic signed [INT_W-1:0] integ_r;

  // stage registers
  logic signed [ERR_W-1:0] s1_err_r;
  logic signed [INT_W-1:0] s1_int_r;
  logic signed [SUM_W-1:0] s1_diff_r;
  logic signed [PP_W-1:0]  s2_p_r;
  logic signed [PI_W-1:0]  s2_i_r;
  logic signed [PD_W-1:0]  s2_d_r;
  logic signed [DRIVE_W-1:0] drive_r;

  logic signed [ERR_W-1:0] err_nxt;
  logic signed [SUM_W-1:0] isum;
  logic signed [INT_W-1:0] int_nxt;
  logic signed [SUM_W-1:0] diff_nxt;
  logic signed [PP_W-1:0]  p_nxt;
  logic signed [PI_W-1:0]  i_nxt;
  logic signed [PD_W-1:0]  d_nxt;
  logic signed [ACC_W-1:0] acc;
  logic signed [SH_W-1:0]  shifted;
  logic signed [SH_W-1:0]  hi_ext;
  logic signed [SH_W-1:0]  lo_ext;
  logic signed [SH_W-1:0]  clamp_hi;
  logic signed [SH_W-1:0]  clamp_lo;

  // stage 1: error, clamped integral, error difference
  always_comb begin
    err_nxt  = ERR_W'(target) - ERR_W'(measured);
    isum     = SUM_W'(integ_r) + SUM_W'(err_nxt);
    if (isum > ILIM_HI) begin
      int_nxt = ILIM_HI[INT_W-1:0];
    end else if (isum < ILIM_LO) begin
      int_nxt = ILIM_LO[INT_W-1:0];
    end else begin
      int_nxt = isum[INT_W-1:0];
    end
    diff_nxt = SUM_W'(err_nxt) - SUM_W'(last_err_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      integ_r    <= '0;
    end else if (ctrl.ld1) begin
      last_err_r <= err_nxt;
      integ_r    <= int_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      s1_err_r  <= err_nxt;
      s1_int_r  <= int_nxt;
      s1_diff_r <= diff_nxt;
    end
  end

  // stage 2: gain products
  assign p_nxt = $signed({1'b0, gain_prop})  * s1_err_r;
  assign i_nxt = $signed({1'b0, gain_integ}) * s1_int_r;
  assign d_nxt = $signed({1'b0, gain_deriv}) * s1_diff_r;

  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      s2_p_r <= p_nxt;
      s2_i_r <= i_nxt;
      s2_d_r <= d_nxt;
    end
  end

  // stage 3: sum, floor shift, upper then lower clamp
  always_comb begin
    acc      = ACC_W'(s2_p_r) + ACC_W'(s2_i_r) + ACC_W'(s2_d_r);
    shifted  = acc[ACC_W-1:GAIN_FRACTION_BITS];
    hi_ext   = SH_W'(drive_max);
    lo_ext   = SH_W'(drive_min);
    clamp_hi = (shifted > hi_ext) ? hi_ext : shifted;
    clamp_lo = (clamp_hi < lo_ext) ? lo_ext : clamp_hi;
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld3) begin
      drive_r <= clamp_lo[DRIVE_W-1:0];
    end
  end

  assign drive = drive_r;

endmodule

`default_nettype wire

@@ src/dual_wheel_pid_speed_controller_top.sv @@
// Dual wheel PID speed controller, top level.
// Channels: the input channel (in_valid / in_stall) carries one control tick
// request: left and right measured speeds and a signed line error. The result
// channel (out_valid / out_stall) returns the clamped left and right drives,
// one result per request. The configuration channel (cfg_valid / cfg_ready,
// always ready) writes gains, base speed and drive clamps by index; writes
// to indexes past drive_min are dropped. Write it only while the block is idle.
// Path: a request passes the error/integral stage, the product stage, the
// sum/shift/clamp stage and the output register before out_valid rises.
// Throughput: one request per cycle unless a stall backs up the pipeline;
// wheel state updates in the first stage, so back-to-back requests
// see the previous tick's error and integral. The two wheels run in parallel
// lanes and the output register merges their drives.
// Stall: every stage holds while the stage after it is full and not moving,
// so bubbles collapse and a request is still taken while a result waits.
// Reset: synchronous, active low; clears pipeline valids, wheel state and
// restores the register defaults.
// depends on dwpid_pkg, dwpid_lane and the assertion macro header
`default_nettype none

module dual_wheel_pid_speed_controller_top (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [dwpid_pkg::SPEED_W-1:0]   in_left_speed,
  input  wire logic signed [dwpid_pkg::SPEED_W-1:0]   in_right_speed,
  input  wire logic signed [dwpid_pkg::LINE_W-1:0]    in_line_error,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed      [dwpid_pkg::DRIVE_W-1:0]   out_left_drive,
  output logic signed      [dwpid_pkg::DRIVE_W-1:0]   out_right_drive,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic        [dwpid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [dwpid_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dwpid_pkg::*;

  // configuration registers
  logic        [GAIN_W-1:0]  gain_prop_r;
  logic        [GAIN_W-1:0]  gain_integ_r;
  logic        [GAIN_W-1:0]  gain_deriv_r;
  logic        [BASE_W-1:0]  base_speed_r;
  logic signed [DRIVE_W-1:0] drive_max_r;
  logic signed [DRIVE_W-1:0] drive_min_r;

  // pipeline valids and output register
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic signed [DRIVE_W-1:0] out_left_r;
  logic signed [DRIVE_W-1:0] out_right_r;

  logic in_take, free1, free2, free3, free_o;
  lane_ctrl_t ctrl;
  logic signed [TGT_W-1:0] left_target;
  logic signed [TGT_W-1:0] right_target;
  logic signed [DRIVE_W-1:0] left_drive;
  logic signed [DRIVE_W-1:0] right_drive;

  // config write port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r  <= GAIN_W'(3277);
      gain_integ_r <= GAIN_W'(532);
      gain_deriv_r <= '0;
      base_speed_r <= BASE_W'(10);
      drive_max_r  <= DRIVE_W'(100);
      drive_min_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_PROP:  gain_prop_r  <= cfg_data;
        REG_GAIN_INTEG: gain_integ_r <= cfg_data;
        REG_GAIN_DERIV: gain_deriv_r <= cfg_data;
        REG_BASE_SPEED: base_speed_r <= cfg_data[BASE_W-1:0];
        REG_DRIVE_MAX:  drive_max_r  <= $signed(cfg_data[DRIVE_W-1:0]);
        REG_DRIVE_MIN:  drive_min_r  <= $signed(cfg_data[DRIVE_W-1:0]);
        default: ;
      endcase
    end
  end

  // stage flow: a stage loads when it is empty or its contents move on
  assign free_o  = !out_valid_r || !out_stall;
  assign free3   = !v3_r || free_o;
  assign free2   = !v2_r || free3;
  assign free1   = !v1_r || free2;
  assign in_stall = !free1;
  assign in_take  = in_valid && free1;

  assign ctrl.ld1 = in_take;
  assign ctrl.ld2 = v1_r && free2;
  assign ctrl.ld3 = v2_r && free3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (free1) v1_r <= in_take;
      if (free2) v2_r <= v1_r;
      if (free3) v3_r <= v2_r;
      if (free_o) out_valid_r <= v3_r;
    end
  end

  // steering split of the base speed
  assign left_target  = TGT_W'($signed({1'b0, base_speed_r})) + TGT_W'(in_line_error);
  assign right_target = TGT_W'($signed({1'b0, base_speed_r})) - TGT_W'(in_line_error);

  // wheel lanes
  dwpid_lane u_left (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .target     (left_target),
    .measured   (in_left_speed),
    .gain_prop  (gain_prop_r),
    .gain_integ (gain_integ_r),
    .gain_deriv (gain_deriv_r),
    .drive_max  (drive_max_r),
    .drive_min  (drive_min_r),
    .drive      (left_drive)
  );

  dwpid_lane u_right (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .target     (right_target),
    .measured   (in_right_speed),
    .gain_prop  (gain_prop_r),
    .gain_integ (gain_integ_r),
    .gain_deriv (gain_deriv_r),
    .drive_max  (drive_max_r),
    .drive_min  (drive_min_r),
    .drive      (right_drive)
  );

  // merge: both lane drives into one result register
  always_ff @(posedge clk) begin
    if (free_o && v3_r) begin
      out_left_r  <= left_drive;
      out_right_r <= right_drive;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_drive  = out_left_r;
  assign out_right_drive = out_right_r;

  // checks
  `include "dual_wheel_pid_speed_controller_top_assert.svh"

  `DWPID_ASSERT_NOW(a_stall_only_when_full, in_stall, v1_r && v2_r && v3_r && out_valid_r, "input stalled with a free stage")
  `DWPID_ASSERT_NEXT(a_last_stage_holds, v3_r && !free_o, v3_r, "last lane stage dropped a request")
  `DWPID_ASSERT_NOW(a_drive_in_clamp, out_valid_r && (drive_min_r <= drive_max_r), (out_left_drive <= drive_max_r) && (out_left_drive >= drive_min_r) && (out_right_drive <= drive_max_r) && (out_right_drive >= drive_min_r), "drive outside clamp range")

endmodule

`default_nettype wire

@@ test/tb.sv @@
// testbench for dual_wheel_pid_speed_controller_top: directed table, then random ticks
// keeps its own pid model of both wheels and checks every drive pair in order
// depends on dwpid_pkg and the controller rtl
`default_nettype none

module tb;
  import dwpid_pkg::*;

  localparam int PIPE_LATENCY  = 4;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RAND_PHASES   = 6;
  localparam int TICKS_PER_SET = 240;
  localparam int HOLD_AFTER    = 400;
  localparam int HOLD_CYCLES   = 300;

  // register indexes past drive_min, dropped by the block
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 3'd7;

  // receiver stall modes
  typedef enum int {
    RX_FLOW,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
  } drive_pair_t;

  typedef struct {
    logic                      is_write;
    logic [CFG_IDX_W-1:0]      idx;
    logic [CFG_DATA_W-1:0]     data;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic signed [LINE_W-1:0]  line_error;
    logic                      known;
    drive_pair_t               known_drives;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SPEED_W-1:0] in_left_speed = '0;
  logic signed [SPEED_W-1:0] in_right_speed = '0;
  logic signed [LINE_W-1:0] in_line_error = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DRIVE_W-1:0] out_left_drive;
  logic signed [DRIVE_W-1:0] out_right_drive;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model copy of the registers and wheel state
  logic [GAIN_W-1:0]         gain_p;
  logic [GAIN_W-1:0]         gain_i;
  logic [GAIN_W-1:0]         gain_d;
  logic [BASE_W-1:0]         base_cur;
  logic signed [DRIVE_W-1:0] drive_hi;
  logic signed [DRIVE_W-1:0] drive_lo;
  logic signed [ERR_W-1:0]   last_err [2];
  logic signed [INT_W-1:0]   integ [2];

  drive_pair_t expected_drives [$];
  stim_row_t   plan [$];

  int failures = 0;
  int ticks_sent = 0;
  int writes_done = 0;
  int drives_checked = 0;
  int burst_left = 0;
  int unsigned cycle_count = 0;

  always #1 clk = ~clk;

  dual_wheel_pid_speed_controller_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_left_speed  (in_left_speed),
    .in_right_speed (in_right_speed),
    .in_line_error  (in_line_error),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left_drive (out_left_drive),
    .out_right_drive(out_right_drive),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // one wheel: error, clamped integral, sum with q4.12 gains floored, then max and min clamps
  function automatic logic signed [DRIVE_W-1:0] wheel_drive(input int w, input longint target,
                                                             input longint measured);
    longint err;
    longint isum;
    longint acc;
    longint drv;
    err  = target - measured;
    isum = longint'(integ[w]) + err;
    if (isum > INTEGRAL_LIMIT) isum = INTEGRAL_LIMIT;
    if (isum < -INTEGRAL_LIMIT) isum = -INTEGRAL_LIMIT;
    acc = longint'(gain_p) * err + longint'(gain_i) * isum
        + longint'(gain_d) * (err - longint'(last_err[w]));
    last_err[w] = err[ERR_W-1:0];
    integ[w]    = isum[INT_W-1:0];
    drv = acc >>> GAIN_FRACTION_BITS;
    if (drv > longint'(drive_hi)) drv = longint'(drive_hi);
    if (drv < longint'(drive_lo)) drv = longint'(drive_lo);
    return drv[DRIVE_W-1:0];
  endfunction

  // both wheels for one control tick, left steers up and right steers down
  function automatic drive_pair_t predict_drives(input logic signed [SPEED_W-1:0] ls,
                                                 input logic signed [SPEED_W-1:0] rs,
                                                 input logic signed [LINE_W-1:0] le);
    drive_pair_t d;
    longint base;
    base = longint'(base_cur);
    d.left_drive  = wheel_drive(0, base + longint'(le), longint'(ls));
    d.right_drive = wheel_drive(1, base - longint'(le), longint'(rs));
    return d;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_GAIN_PROP:  gain_p = data;
      REG_GAIN_INTEG: gain_i = data;
      REG_GAIN_DERIV: gain_d = data;
      REG_BASE_SPEED: base_cur = data[BASE_W-1:0];
      REG_DRIVE_MAX:  drive_hi = data[DRIVE_W-1:0];
      REG_DRIVE_MIN:  drive_lo = data[DRIVE_W-1:0];
      default: ;
    endcase
  endfunction

  // table builders
  function automatic void plan_tick(input int ls, input int rs, input int le);
    stim_row_t row;
    row = '{default: '0};
    row.left_speed  = ls[SPEED_W-1:0];
    row.right_speed = rs[SPEED_W-1:0];
    row.line_error  = le[LINE_W-1:0];
    plan.push_back(row);
  endfunction

  function automatic void plan_checked(input int ls, input int rs, input int le,
                                       input int kl, input int kr);
    plan_tick(ls, rs, le);
    plan[$].known = 1'b1;
    plan[$].known_drives.left_drive  = kl[DRIVE_W-1:0];
    plan[$].known_drives.right_drive = kr[DRIVE_W-1:0];
  endfunction

  function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx, input int val);
    stim_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.idx      = idx;
    row.data     = val[CFG_DATA_W-1:0];
    plan.push_back(row);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 8) return GAIN_W'($urandom_range(0, 8191));
    return GAIN_W'($urandom_range(0, 65535));
  endfunction

  // measured speed: mostly near the target, sometimes anywhere in range
  function automatic logic signed [SPEED_W-1:0] pick_speed();
    if ($urandom_range(0, 9) < 2) return SPEED_W'($urandom());
    return SPEED_W'(int'(base_cur) + int'($urandom_range(0, 600)) - 300);
  endfunction

  // register write request, valid stays up until the next tick lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_write(idx, data);
    writes_done++;
  endtask

  // offer one tick request, record the expected drives, then maybe pause the burst
  task automatic send_tick(input stim_row_t row);
    drive_pair_t want;
    int gap;
    if (cfg_valid) cfg_valid <= 1'b0;
    in_valid       <= 1'b1;
    in_left_speed  <= row.left_speed;
    in_right_speed <= row.right_speed;
    in_line_error  <= row.line_error;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = predict_drives(row.left_speed, row.right_speed, row.line_error);
    if (row.known) want = row.known_drives;
    expected_drives.push_back(want);
    ticks_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain the pipeline before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // receiver stall pattern with one long hold-off to back the block up
  rx_mode_t rx_mode = RX_FLOW;
  int rx_mode_left = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && ticks_sent >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(32, 200);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_FLOW:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= (cycle_count % 4 == 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin : check_drives
    drive_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_drives.size() == 0) begin
        $error("drive pair with no pending tick: left %0d right %0d",
               out_left_drive, out_right_drive);
        failures++;
      end else begin
        want = expected_drives.pop_front();
        drives_checked++;
        if (out_left_drive !== want.left_drive) begin
          $error("left_drive expected %0d got %0d", want.left_drive, out_left_drive);
          failures++;
        end
        if (out_right_drive !== want.right_drive) begin
          $error("right_drive expected %0d got %0d", want.right_drive, out_right_drive);
          failures++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic last_tick;
    int directed_ticks;
    int lo_val;
    int hi_val;
    stim_row_t row;

    // register defaults and cleared wheel state
    gain_p   = 16'd3277;
    gain_i   = 16'd532;
    gain_d   = '0;
    base_cur = 10'd10;
    drive_hi = 11'sd100;
    drive_lo = '0;
    last_err = '{default: '0};
    integ    = '{default: '0};

    // reset defaults, speed and line error extremes saturate the clamps
    plan_checked(-32768, 32767, 127, 100, 0);
    plan_checked(32767, -32768, -128, 0, 100);
    plan_tick(0, 0, 0);
    plan_tick(10, 10, 0);
    plan_tick(5, 15, 5);
    // full gains and widest clamps
    plan_write(REG_GAIN_PROP, 65535);
    plan_write(REG_GAIN_INTEG, 65535);
    plan_write(REG_GAIN_DERIV, 65535);
    plan_write(REG_BASE_SPEED, 1023);
    plan_write(REG_DRIVE_MAX, 1023);
    plan_write(REG_DRIVE_MIN, -1024);
    plan_checked(-32768, -32768, 127, 1023, 1023);
    plan_checked(32767, 32767, -128, -1024, -1024);
    plan_tick(1023, 1023, 0);
    plan_tick(900, 1100, -50);
    // crossed clamps force drive_min, spare index must not disturb anything
    plan_write(REG_GAIN_PROP, 0);
    plan_write(REG_GAIN_INTEG, 0);
    plan_write(REG_GAIN_DERIV, 0);
    plan_write(REG_DRIVE_MAX, -1024);
    plan_write(REG_DRIVE_MIN, 1023);
    plan_write(CFG_IDX_SPARE, 65535);
    plan_checked(0, 0, 0, 1023, 1023);
    plan_checked(1234, -4321, -77, 1023, 1023);
    // half gain on small errors shows the shift floors toward minus infinity
    plan_write(REG_GAIN_PROP, 2048);
    plan_write(REG_BASE_SPEED, 0);
    plan_write(REG_DRIVE_MAX, 1023);
    plan_write(REG_DRIVE_MIN, -1024);
    plan_checked(1, 1, 0, -1, -1);
    plan_checked(-1, -1, 0, 0, 0);
    plan_checked(-3, 3, 0, 1, -2);
    // unity gains, all three terms live
    plan_write(REG_GAIN_PROP, 4096);
    plan_write(REG_GAIN_INTEG, 4096);
    plan_write(REG_GAIN_DERIV, 4096);
    plan_tick(-100, 100, 20);
    plan_tick(50, -50, -20);
    plan_tick(0, 0, 127);
    plan_tick(-200, -200, -128);
    plan_tick(7, -7, 1);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    last_tick = 1'b0;
    foreach (plan[k]) begin
      if (plan[k].is_write) begin
        if (last_tick) settle();
        write_reg(plan[k].idx, plan[k].data);
        last_tick = 1'b0;
      end else begin
        send_tick(plan[k]);
        last_tick = 1'b1;
      end
    end
    directed_ticks = ticks_sent;

    // random register sets, each followed by a run of random ticks
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      settle();
      write_reg(REG_GAIN_PROP, pick_gain());
      write_reg(REG_GAIN_INTEG, pick_gain());
      write_reg(REG_GAIN_DERIV, pick_gain());
      case ($urandom_range(0, 9))
        0: write_reg(REG_BASE_SPEED, 16'd0);
        1: write_reg(REG_BASE_SPEED, 16'd1023);
        default: write_reg(REG_BASE_SPEED, CFG_DATA_W'($urandom_range(0, 1023)));
      endcase
      case ($urandom_range(0, 9))
        0: begin
          lo_val = $urandom_range(0, 1023);
          hi_val = -int'($urandom_range(0, 1024));
        end
        1: begin
          lo_val = -1024;
          hi_val = 1023;
        end
        default: begin
          lo_val = -int'($urandom_range(0, 1024));
          hi_val = $urandom_range(0, 1023);
        end
      endcase
      write_reg(REG_DRIVE_MAX, CFG_DATA_W'(hi_val));
      write_reg(REG_DRIVE_MIN, CFG_DATA_W'(lo_val));
      if ($urandom_range(0, 1) == 0) write_reg(CFG_IDX_TOP, CFG_DATA_W'($urandom()));
      for (int n = 0; n < TICKS_PER_SET; n++) begin
        row = '{default: '0};
        row.left_speed  = pick_speed();
        row.right_speed = pick_speed();
        row.line_error  = LINE_W'($urandom_range(0, 255));
        send_tick(row);
      end
    end

    // drain and let the pipeline go quiet
    in_valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY * 4) @(posedge clk);

    $display("control ticks sent: %0d (%0d from the directed table), register writes: %0d",
             ticks_sent, directed_ticks, writes_done);
    $display("drive pairs compared: %0d, mismatches: %0d", drives_checked, failures);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ dual_wheel_pid_speed_controller_top.f @@
+incdir+src
src/dwpid_pkg.sv
src/dwpid_lane.sv
src/dual_wheel_pid_speed_controller_top.sv
test/tb.sv
